// ----- src/bwu_pkg.sv -----
// ----------------------------------------------------------------------------
// bwu_pkg: shared constants and types for the bounded-weight unranking block
// Table geometry, field widths, register indexes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bwu_pkg;

    // Table geometry: counts for string lengths and budgets 0..MAX_LENGTH.
    localparam int MAX_LENGTH = 31;
    localparam int TAB_DIM    = MAX_LENGTH + 1;
    localparam int IDX_W      = $clog2(TAB_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int TAB_DEPTH  = TAB_DIM * TAB_DIM;

    // Field widths.
    localparam int CNT_W     = 32;
    localparam int RANK_W    = 32;
    localparam int PAT_W     = 31;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_STRING_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ONES      = 1'b1;
    localparam logic [CFG_W-1:0]     RST_STRING_LENGTH = 5'd31;
    localparam logic [CFG_W-1:0]     RST_MAX_ONES      = 5'd31;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill;   // build the count table
        logic load;   // capture a new request
        logic check;  // compare the rank with the total count
        logic walk;   // decide one bit of the pattern
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_done;  // last table entry is being written
        logic range_bad;  // rank is zero or past the total
        logic len_zero;   // string length is zero
        logic last_bit;   // the walk is at bit zero
    } t_dp_status;

    // Saturate a register value to the table range.
    function automatic logic [IDX_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [IDX_W-1:0] res;
        if (v > CFG_W'(MAX_LENGTH)) begin
            res = IDX_W'(MAX_LENGTH);
        end else begin
            res = IDX_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/bwu_ram.sv -----
// ----------------------------------------------------------------------------
// bwu_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/bwu_datapath.sv -----
// ----------------------------------------------------------------------------
// bwu_datapath: count table, rank walk and configuration registers
// Builds the cumulative binomial table by Pascal's rule after reset, then
// decides one pattern bit per cycle from two table copies that are read for
// both possible budgets of the next bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bwu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bwu_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic [bwu_pkg::RANK_W-1:0]       i_rank,
    input  wire bwu_pkg::t_dp_cmd                 i_cmd,
    output bwu_pkg::t_dp_status                   o_status,
    output logic      [bwu_pkg::PAT_W-1:0]        o_pattern,
    output logic                                  o_out_of_range
);

    import bwu_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]  r_string_length;
    logic [CFG_W-1:0]  r_max_ones;

    // Table build.
    logic [ADDR_W:0]   r_fill_cnt;
    logic              r_wr_vld;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [CNT_W-1:0]  r_prev;

    // Walk.
    logic [RANK_W-1:0] r_rank;
    logic [IDX_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_bit;
    logic [IDX_W-1:0]  r_budget;
    logic              r_took;
    logic [PAT_W-1:0]  r_pattern;
    logic              r_oor;

    logic              fill_issue;
    logic [IDX_W-1:0]  cfg_len;
    logic [IDX_W-1:0]  cfg_budget;
    logic [IDX_W-1:0]  budget_dec;
    logic [IDX_W-1:0]  rd_row;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [CNT_W-1:0]  rd_a;
    logic [CNT_W-1:0]  rd_b;
    logic [CNT_W-1:0]  wr_data;
    logic [CNT_W-1:0]  cur_cnt;
    logic              rank_gt;

    assign fill_issue = i_cmd.fill && !r_fill_cnt[ADDR_W];
    assign cfg_len    = clamp_len(r_string_length);
    assign cfg_budget = clamp_len(r_max_ones);
    assign budget_dec = (r_budget == '0) ? '0 : r_budget - IDX_W'(1);
    assign rd_row     = i_cmd.check ? r_len - IDX_W'(1) : r_bit - IDX_W'(1);

    // Read address of copy A: previous row during the build, the total on a
    // new request, otherwise the next bit's row at the current budget.
    always_comb begin
        priority if (i_cmd.fill) begin
            rd_addr_a = r_fill_cnt[ADDR_W-1:0] - ADDR_W'(TAB_DIM);
        end else if (i_cmd.load) begin
            rd_addr_a = {cfg_len, cfg_budget};
        end else begin
            rd_addr_a = {rd_row, r_budget};
        end
    end

    // Copy B serves the budget one lower, for when the current bit is set.
    assign rd_addr_b = {rd_row, budget_dec};

    // Pascal's rule: row zero is all ones, column zero copies the row above.
    always_comb begin
        priority if (r_wr_addr[ADDR_W-1:IDX_W] == '0) begin
            wr_data = CNT_W'(1);
        end else if (r_wr_addr[IDX_W-1:0] == '0) begin
            wr_data = rd_a;
        end else begin
            wr_data = rd_a + r_prev;
        end
    end

    // Count for the current bit, picked by the previous decision.
    assign cur_cnt = r_took ? rd_b : rd_a;
    assign rank_gt = r_rank > cur_cnt;

    bwu_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TAB_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (r_wr_vld),
        .i_waddr (r_wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr_a),
        .o_rdata (rd_a)
    );

    bwu_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TAB_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (r_wr_vld),
        .i_waddr (r_wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr_b),
        .o_rdata (rd_b)
    );

    // Configuration and table-build control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_string_length <= RST_STRING_LENGTH;
            r_max_ones      <= RST_MAX_ONES;
            r_fill_cnt      <= '0;
            r_wr_vld        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STRING_LENGTH: r_string_length <= i_cfg_data;
                    CFG_MAX_ONES:      r_max_ones      <= i_cfg_data;
                    default:           r_max_ones      <= r_max_ones;
                endcase
            end
            if (fill_issue) begin
                r_fill_cnt <= r_fill_cnt + (ADDR_W + 1)'(1);
            end
            r_wr_vld <= fill_issue;
        end
    end

    // Table-build write stage.
    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_fill_cnt[ADDR_W-1:0];
        if (r_wr_vld) begin
            r_prev <= rd_a;
        end
    end

    // Request capture, range check and one bit decision per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rank    <= i_rank;
            r_len     <= cfg_len;
            r_budget  <= cfg_budget;
            r_pattern <= '0;
            r_oor     <= 1'b0;
        end
        if (i_cmd.check) begin
            r_oor  <= o_status.range_bad;
            r_bit  <= r_len - IDX_W'(1);
            r_took <= 1'b0;
        end
        if (i_cmd.walk) begin
            r_took <= rank_gt;
            r_bit  <= r_bit - IDX_W'(1);
            if (rank_gt) begin
                r_pattern[r_bit] <= 1'b1;
                r_rank           <= r_rank - cur_cnt;
                r_budget         <= budget_dec;
            end
        end
    end

    assign o_status.fill_done = r_wr_vld && (r_wr_addr == ADDR_W'(TAB_DEPTH - 1));
    assign o_status.range_bad = (r_rank == '0) || (r_rank > rd_a);
    assign o_status.len_zero  = (r_len == '0);
    assign o_status.last_bit  = (r_bit == '0);

    assign o_pattern      = r_pattern;
    assign o_out_of_range = r_oor;

endmodule

`default_nettype wire

// ----- src/bwu_ctrl.sv -----
// ----------------------------------------------------------------------------
// bwu_ctrl: sequencing state machine
// Runs the table build after reset, then takes one request at a time through
// range check, bit walk and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire bwu_pkg::t_dp_status i_status,
    output bwu_pkg::t_dp_cmd         o_cmd,
    output logic                     o_busy,
    output logic                     o_valid
);

    import bwu_pkg::*;

    localparam logic [2:0] S_FILL  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_status.range_bad || i_status.len_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.last_bit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the table build.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

`default_nettype wire

// ----- src/bounded_weight_unrank_top.sv -----
// ----------------------------------------------------------------------------
// bounded_weight_unrank_top: bounded-weight binary string unranking
// Returns the rank-th string, in ascending order, of all strings of the
// configured length that hold at most the configured number of ones.
//
//   Channel   Signals                               Transfer
//   request   start, busy, i_rank                   start && !busy
//   result    o_valid, o_pattern, o_out_of_range    o_valid, one cycle
//   config    i_cfg_we, i_cfg_idx, i_cfg_data       i_cfg_we
//
// A request reads the table once for the total, then decides one bit per cycle,
// bound by the registered table read. A rank out of range skips the walk.
// busy stays high through the strobe, so a new request is taken only after
// the result. After reset busy stays high while the table is built.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_weight_unrank_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [bwu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bwu_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [bwu_pkg::RANK_W-1:0]    i_rank,
    output logic                               o_valid,
    output logic      [bwu_pkg::PAT_W-1:0]     o_pattern,
    output logic                               o_out_of_range
);

    import bwu_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer.
    bwu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // Count table and walk.
    bwu_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rank         (i_rank),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_pattern      (o_pattern),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire

// ----- src/bwu_checker.sv -----
// ----------------------------------------------------------------------------
// bwu_checker: port-level checks for the unranking block
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      o_valid,
    input wire logic                      o_out_of_range,
    input wire logic [bwu_pkg::PAT_W-1:0] o_pattern
);

    // Reset always starts the table build, so the block reads busy.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block not busy after reset");

    // An accepted request makes the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // A result strobe lasts one cycle and never appears while idle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // A rank out of range gives an all-zero pattern.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_pattern == '0))
        else $error("nonzero pattern with out-of-range flag");

endmodule

bind bounded_weight_unrank_top bwu_checker u_bwu_checker (.*);

`default_nettype wire
